// File: hdl/plcd_pkg.sv
// Shared types, sizes and command codes of the page-mode panel flush block.
package plcd_pkg;

    localparam int COLUMNS     = 132;
    localparam int PAGES       = 8;
    localparam int STORE_BYTES = COLUMNS * PAGES;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int PTR_W       = $clog2(STORE_BYTES + 1);
    localparam int COL_W       = $clog2(COLUMNS);
    localparam int PAGE_W      = (PAGES > 1) ? $clog2(PAGES) : 1;

    localparam logic [1:0] REQ_SET   = 2'd0;
    localparam logic [1:0] REQ_CLEAR = 2'd1;
    localparam logic [1:0] REQ_FLUSH = 2'd2;

    localparam logic [7:0] PAGE_CMD   = 8'hB0;
    localparam logic [7:0] COL_LO_CMD = 8'h00;
    localparam logic [7:0] COL_HI_CMD = 8'h10;
    localparam logic [7:0] NIB_MASK   = 8'h0F;
    localparam logic [7:0] DONE_BYTE  = 8'h00;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] pixel_x;
        logic [7:0] pixel_y;
    } t_request;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_data;
        logic       last;
        logic       scan_done;
    } t_result;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ADDR_W-1:0] idx;
        logic [2:0]        bit_sel;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_link;

    typedef struct packed {
        logic cmd_pop;
        logic init_busy;
    } t_back_ctl;

endpackage

// File: hdl/plcd_front.sv
// Front end: accepts requests, drops those without effect and queues the rest.
module plcd_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  plcd_pkg::t_request i_req,
    input  plcd_pkg::t_back_ctl i_ctl,
    output plcd_pkg::t_cmd_link o_link
);
    import plcd_pkg::*;

    t_cmd       r_q [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;
    logic       w_keep, w_enq, w_deq;
    t_cmd       w_cmd;

    always_comb begin
        w_cmd.kind    = i_req.req_type;
        w_cmd.idx     = ADDR_W'(ADDR_W'(i_req.pixel_x) * ADDR_W'(PAGES)
                        + ADDR_W'(i_req.pixel_y[7:3]));
        w_cmd.bit_sel = i_req.pixel_y[2:0];
        case (i_req.req_type)
            REQ_SET: begin
                // Pixels off the panel are dropped here and never reach the back end.
                w_keep = ({1'b0, i_req.pixel_x} < 9'(COLUMNS))
                      && ({1'b0, i_req.pixel_y} < 9'(8 * PAGES));
            end
            REQ_CLEAR: w_keep = 1'b1;
            REQ_FLUSH: w_keep = 1'b1;
            default:   w_keep = 1'b0;
        endcase
    end

    assign full         = (r_count == 2'd2) || i_ctl.init_busy;
    assign w_enq        = push && !full && w_keep;
    assign w_deq        = i_ctl.cmd_pop;
    assign o_link.valid = (r_count != 2'd0);
    assign o_link.cmd   = r_q[r_rd_ptr];
    assign n_count      = r_count + {1'b0, w_enq} - {1'b0, w_deq};

    always_ff @(posedge i_clk) begin
        if (w_enq) begin
            r_q[r_wr_ptr] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_enq) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_deq) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

endmodule

// File: hdl/plcd_back.sv
// Back end: drawing and shadow stores, clearing sweeps, pixel writes and the flush scan.
module plcd_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  plcd_pkg::t_cmd_link i_cmd,
    output plcd_pkg::t_back_ctl o_ctl,
    input  logic                i_out_full,
    output logic                o_res_push,
    output plcd_pkg::t_result   o_res
);
    import plcd_pkg::*;

    localparam logic [2:0] S_WIPE     = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_SET_WR   = 3'd2;
    localparam logic [2:0] S_SCAN_RD  = 3'd3;
    localparam logic [2:0] S_SCAN_CMP = 3'd4;
    localparam logic [2:0] S_EMIT     = 3'd5;

    logic [7:0] draw_mem  [STORE_BYTES];
    logic [7:0] shown_mem [STORE_BYTES];

    logic [2:0]        r_state, n_state;
    logic [ADDR_W-1:0] r_sweep, n_sweep;
    logic              r_wipe_all, n_wipe_all;
    logic [PTR_W-1:0]  r_ptr, n_ptr;
    logic [COL_W-1:0]  r_col, n_col;
    logic [PAGE_W-1:0] r_page, n_page;
    logic [ADDR_W-1:0] r_set_idx, n_set_idx;
    logic [2:0]        r_set_bit, n_set_bit;
    logic [1:0]        r_emit_k, n_emit_k;
    logic              r_done, n_done;
    logic [COL_W-1:0]  r_f_col, n_f_col;
    logic [PAGE_W-1:0] r_f_page, n_f_page;
    logic [7:0]        r_data, n_data;
    logic [7:0]        r_draw_q, r_shown_q;

    logic              w_draw_we, w_shown_we, w_rd_en;
    logic [ADDR_W-1:0] w_draw_waddr, w_shown_waddr, w_raddr;
    logic [7:0]        w_draw_wdata, w_shown_wdata;
    logic [7:0]        w_col8;

    assign w_col8 = 8'(r_f_col);

    always_comb begin
        n_state    = r_state;
        n_sweep    = r_sweep;
        n_wipe_all = r_wipe_all;
        n_ptr      = r_ptr;
        n_col      = r_col;
        n_page     = r_page;
        n_set_idx  = r_set_idx;
        n_set_bit  = r_set_bit;
        n_emit_k   = r_emit_k;
        n_done     = r_done;
        n_f_col    = r_f_col;
        n_f_page   = r_f_page;
        n_data     = r_data;

        w_draw_we     = 1'b0;
        w_draw_waddr  = r_sweep;
        w_draw_wdata  = 8'h00;
        w_shown_we    = 1'b0;
        w_shown_waddr = r_sweep;
        w_shown_wdata = 8'h00;
        w_rd_en       = 1'b0;
        w_raddr       = r_ptr[ADDR_W-1:0];
        o_res_push    = 1'b0;

        o_ctl.cmd_pop   = 1'b0;
        o_ctl.init_busy = (r_state == S_WIPE) && r_wipe_all;

        case (r_state)
            S_WIPE: begin
                // After reset both stores are swept; a clear request sweeps the drawing only.
                w_draw_we  = 1'b1;
                w_shown_we = r_wipe_all;
                n_sweep    = r_sweep + 1'b1;
                if (r_sweep == ADDR_W'(STORE_BYTES - 1)) begin
                    n_sweep    = '0;
                    n_wipe_all = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_cmd.valid) begin
                    o_ctl.cmd_pop = 1'b1;
                    case (i_cmd.cmd.kind)
                        REQ_SET: begin
                            w_rd_en   = 1'b1;
                            w_raddr   = i_cmd.cmd.idx;
                            n_set_idx = i_cmd.cmd.idx;
                            n_set_bit = i_cmd.cmd.bit_sel;
                            n_state   = S_SET_WR;
                        end
                        REQ_CLEAR: begin
                            n_sweep = '0;
                            n_state = S_WIPE;
                        end
                        REQ_FLUSH: n_state = S_SCAN_RD;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_SET_WR: begin
                w_draw_we    = 1'b1;
                w_draw_waddr = r_set_idx;
                w_draw_wdata = r_draw_q | (8'h01 << r_set_bit);
                n_state      = S_IDLE;
            end
            S_SCAN_RD: begin
                if (r_ptr >= PTR_W'(STORE_BYTES)) begin
                    // Nothing left to update: one done marker and the scan starts over.
                    n_done   = 1'b1;
                    n_emit_k = 2'd0;
                    n_ptr    = '0;
                    n_col    = '0;
                    n_page   = '0;
                    n_state  = S_EMIT;
                end else begin
                    w_rd_en = 1'b1;
                    n_state = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP: begin
                n_ptr = r_ptr + 1'b1;
                if (r_page == PAGE_W'(PAGES - 1)) begin
                    n_page = '0;
                    n_col  = r_col + 1'b1;
                end else begin
                    n_page = r_page + 1'b1;
                end
                if (r_draw_q != r_shown_q) begin
                    w_shown_we    = 1'b1;
                    w_shown_waddr = r_ptr[ADDR_W-1:0];
                    w_shown_wdata = r_draw_q;
                    n_data        = r_draw_q;
                    n_f_col       = r_col;
                    n_f_page      = r_page;
                    n_done        = 1'b0;
                    n_emit_k      = 2'd0;
                    n_state       = S_EMIT;
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_EMIT: begin
                if (!i_out_full) begin
                    o_res_push = 1'b1;
                    if (r_done || (r_emit_k == 2'd3)) begin
                        n_done  = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        n_emit_k = r_emit_k + 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_res.scan_done = r_done;
        o_res.last      = r_done || (r_emit_k == 2'd3);
        o_res.is_data   = !r_done && (r_emit_k == 2'd3);
        if (r_done) begin
            o_res.out_byte = DONE_BYTE;
        end else begin
            case (r_emit_k)
                2'd0:    o_res.out_byte = PAGE_CMD | 8'(r_f_page);
                2'd1:    o_res.out_byte = COL_LO_CMD | (w_col8 & NIB_MASK);
                2'd2:    o_res.out_byte = COL_HI_CMD | ((w_col8 >> 4) & NIB_MASK);
                default: o_res.out_byte = r_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_draw_we) begin
            draw_mem[w_draw_waddr] <= w_draw_wdata;
        end
        if (w_rd_en) begin
            r_draw_q <= draw_mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_shown_we) begin
            shown_mem[w_shown_waddr] <= w_shown_wdata;
        end
        if (w_rd_en) begin
            r_shown_q <= shown_mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_set_idx <= n_set_idx;
        r_set_bit <= n_set_bit;
        r_f_col   <= n_f_col;
        r_f_page  <= n_f_page;
        r_data    <= n_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_WIPE;
            r_sweep    <= '0;
            r_wipe_all <= 1'b1;
            r_ptr      <= '0;
            r_col      <= '0;
            r_page     <= '0;
            r_emit_k   <= 2'd0;
            r_done     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_sweep    <= n_sweep;
            r_wipe_all <= n_wipe_all;
            r_ptr      <= n_ptr;
            r_col      <= n_col;
            r_page     <= n_page;
            r_emit_k   <= n_emit_k;
            r_done     <= n_done;
        end
    end

endmodule

// File: hdl/plcd_out_queue.sv
// Four-entry result queue between the back end and the panel-side reader.
module plcd_out_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  plcd_pkg::t_result i_res,
    output logic              o_full,
    output logic              empty,
    input  logic              pop,
    output plcd_pkg::t_result o_res
);
    import plcd_pkg::*;

    t_result    r_q [4];
    logic [1:0] r_wr_ptr, r_rd_ptr;
    logic [2:0] r_count;
    logic       w_enq, w_deq;

    assign o_full = (r_count == 3'd4);
    assign empty  = (r_count == 3'd0);
    assign w_enq  = i_push && !o_full;
    assign w_deq  = pop && !empty;
    assign o_res  = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_enq) begin
            r_q[r_wr_ptr] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 2'd0;
            r_rd_ptr <= 2'd0;
            r_count  <= 3'd0;
        end else begin
            if (w_enq) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_deq) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + {2'b00, w_enq} - {2'b00, w_deq};
        end
    end

endmodule

// File: hdl/page_lcd_dirty_flush.sv
// Top level of the page-mode panel framebuffer with dirty-byte flush.
//
// Requests enter through a queue-style port: a transaction completes when push is high
// and full is low. Set-pixel, clear and flush-step requests are classified up front and
// held in a two-entry command queue; off-panel pixels and unused codes are dropped there.
// Panel bytes leave through a four-entry result queue: the oldest byte is shown while
// empty is low and is taken when pop is high.
// Steps in the back end, which does one command at a time:
//   set pixel: take the command and read the byte, then write it back.
//   clear: take the command, then sweep the drawing store one byte a cycle.
//   flush step: take the command, read then compare each byte examined, and take one
//   more step when the scan reaches the end of the store; then emit one byte per cycle
//   while the result queue is not full, four for an update and one for the done marker.
// Each request is registered in the command queue before the back end sees it, and each
// emitted byte is registered in the result queue before it appears on the result ports.
// After reset the back end sweeps both stores to zero, one byte a cycle, and holds full
// high until that sweep ends. When the reader stalls, the result queue fills and
// the back end waits with its next byte; the command queue keeps taking requests until
// it too is full.
module page_lcd_dirty_flush (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  plcd_pkg::t_request i_req,
    output logic               empty,
    input  logic               pop,
    output plcd_pkg::t_result  o_res
);
    import plcd_pkg::*;

    t_cmd_link w_link;
    t_back_ctl w_ctl;
    logic      w_res_push, w_out_full;
    t_result   w_res;

    plcd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_req   (i_req),
        .i_ctl   (w_ctl),
        .o_link  (w_link)
    );

    plcd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_link),
        .o_ctl      (w_ctl),
        .i_out_full (w_out_full),
        .o_res_push (w_res_push),
        .o_res      (w_res)
    );

    plcd_out_queue u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_res   (w_res),
        .o_full  (w_out_full),
        .empty   (empty),
        .pop     (pop),
        .o_res   (o_res)
    );

endmodule

// File: hdl/plcd_checker.sv
// Port-level checks of the flush block, bound to its top level.
module plcd_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               push,
    input logic               full,
    input plcd_pkg::t_request i_req,
    input logic               empty,
    input logic               pop,
    input plcd_pkg::t_result  o_res
);
    import plcd_pkg::*;

    // The clearing sweep after reset must hold off requests.
    a_full_after_reset: assert property (@(posedge i_clk) !i_rst_n |=> full)
        else $error("full low straight after reset");

    a_empty_after_reset: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_res)))
        else $error("waiting result changed or vanished");

    a_done_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_res.scan_done) |->
        (o_res.last && !o_res.is_data && (o_res.out_byte == DONE_BYTE)))
        else $error("malformed done marker");

    a_data_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_res.is_data) |-> (o_res.last && !o_res.scan_done))
        else $error("data byte not marked last");

endmodule

bind page_lcd_dirty_flush plcd_checker u_checker (.*);

// File: tb/sv/tb_top.sv
// Self-checking testbench for the page-mode panel framebuffer with dirty-byte flush.
module tb_top;
    import plcd_pkg::*;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int TAIL_CYCLES = 2 * STORE_BYTES + 64;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     push = 1'b0;
    logic     full;
    t_request i_req = '0;
    logic     empty;
    logic     pop = 1'b0;
    t_result  o_res;

    // Own copy of the block state, advanced as each transaction is accepted.
    logic [7:0] drawn_bytes [STORE_BYTES];
    logic [7:0] shown_bytes [STORE_BYTES];
    int         scan_idx;
    t_result    panel_bytes_due [$];

    int send_idle = 0;
    int recv_idle = 0;
    int items_done = 0;
    int mismatches = 0;
    int cycle_count = 0;

    page_lcd_dirty_flush DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_req   (i_req),
        .empty   (empty),
        .pop     (pop),
        .o_res   (o_res)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Returns the number of panel bytes the request causes, or -1 if it is ignored.
    function automatic int predict_panel_bytes(t_request r);
        int         idx;
        logic [7:0] col;
        logic [7:0] page;
        case (r.req_type)
            REQ_SET: begin
                if (r.pixel_x < COLUMNS && r.pixel_y < 8 * PAGES) begin
                    idx = r.pixel_x * PAGES + r.pixel_y / 8;
                    drawn_bytes[idx] = drawn_bytes[idx] | (8'd1 << r.pixel_y[2:0]);
                    return 0;
                end
                return -1;
            end
            REQ_CLEAR: begin
                foreach (drawn_bytes[i]) drawn_bytes[i] = 8'd0;
                return 0;
            end
            REQ_FLUSH: begin
                for (idx = scan_idx; idx < STORE_BYTES; idx++) begin
                    if (drawn_bytes[idx] != shown_bytes[idx]) begin
                        col = 8'(idx / PAGES);
                        page = 8'(idx % PAGES);
                        shown_bytes[idx] = drawn_bytes[idx];
                        scan_idx = idx + 1;
                        panel_bytes_due.push_back('{PAGE_CMD | page, 1'b0, 1'b0, 1'b0});
                        panel_bytes_due.push_back('{COL_LO_CMD | (col & NIB_MASK),
                                                    1'b0, 1'b0, 1'b0});
                        panel_bytes_due.push_back('{COL_HI_CMD | (col >> 4),
                                                    1'b0, 1'b0, 1'b0});
                        panel_bytes_due.push_back('{drawn_bytes[idx], 1'b1, 1'b1, 1'b0});
                        return 4;
                    end
                end
                // Nothing left to update: the scan rewinds and reports completion.
                scan_idx = 0;
                panel_bytes_due.push_back('{DONE_BYTE, 1'b0, 1'b1, 1'b1});
                return 1;
            end
            default: return -1;
        endcase
    endfunction

    function automatic t_request make_request(logic [1:0] kind, logic [7:0] x, logic [7:0] y);
        t_request r;
        r.req_type = kind;
        r.pixel_x = x;
        r.pixel_y = y;
        return r;
    endfunction

    // Entered and left at a rising edge; push stays high after the transaction.
    task automatic send_request(input t_request r, output int n_out);
        while ($urandom_range(99) < send_idle) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_req <= r;
        @(negedge i_clk);
        while (full) @(negedge i_clk);
        @(posedge i_clk);
        n_out = predict_panel_bytes(r);
        if (n_out >= 0) items_done++;
    endtask

    task automatic wait_results_drained;
        push <= 1'b0;
        while (panel_bytes_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_random_pixels(int count);
        int n;
        repeat (count) begin
            send_request(make_request(REQ_SET, 8'($urandom_range(COLUMNS - 1)),
                                      8'($urandom_range(8 * PAGES - 1))), n);
        end
    endtask

    task automatic flush_until_done;
        int n;
        int tries;
        n = 0;
        tries = 0;
        while (n != 1 && tries < 24) begin
            send_request(make_request(REQ_FLUSH, 8'($urandom_range(255)),
                                      8'($urandom_range(255))), n);
            tries++;
        end
    endtask

    task automatic test_directed_cases;
        int n;
        send_request(make_request(REQ_SET, 8'd0, 8'd0), n);
        send_request(make_request(REQ_SET, 8'(COLUMNS - 1), 8'(8 * PAGES - 1)), n);
        // Pixels just beyond the panel edge and an unused request code change nothing.
        send_request(make_request(REQ_SET, 8'(COLUMNS), 8'd0), n);
        send_request(make_request(REQ_SET, 8'd0, 8'(8 * PAGES)), n);
        send_request(make_request(REQ_SET, 8'hFF, 8'hFF), n);
        send_request(make_request(2'd3, 8'hFF, 8'hFF), n);
        send_request(make_request(REQ_FLUSH, 8'h00, 8'h00), n);
        send_request(make_request(REQ_FLUSH, 8'hFF, 8'hFF), n);
        send_request(make_request(REQ_FLUSH, 8'h00, 8'h00), n);
        // A byte dirtied behind the scan pointer is only found after the rewind.
        send_request(make_request(REQ_SET, 8'd100, 8'd10), n);
        send_request(make_request(REQ_FLUSH, 8'h00, 8'h00), n);
        send_request(make_request(REQ_SET, 8'd5, 8'd7), n);
        send_request(make_request(REQ_FLUSH, 8'h00, 8'h00), n);
        send_request(make_request(REQ_FLUSH, 8'h00, 8'h00), n);
        send_request(make_request(REQ_FLUSH, 8'h00, 8'h00), n);
        // Clearing leaves the shadow alone, so every shown byte is flushed back to zero.
        send_request(make_request(REQ_CLEAR, 8'hFF, 8'hFF), n);
        repeat (5) send_request(make_request(REQ_FLUSH, 8'h00, 8'h00), n);
        send_request(make_request(REQ_SET, 8'd128, 8'd1), n);
        send_request(make_request(REQ_SET, 8'd128, 8'd1), n);
        send_request(make_request(REQ_SET, 8'd128, 8'd0), n);
        send_request(make_request(REQ_FLUSH, 8'h00, 8'h00), n);
        send_request(make_request(REQ_FLUSH, 8'h00, 8'h00), n);
        wait_results_drained();
    endtask

    task automatic test_random_traffic(int sender_idle, int receiver_idle, int quota);
        int target;
        int pick;
        int n;
        send_idle = sender_idle;
        recv_idle = receiver_idle;
        target = items_done + quota;
        while (items_done < target) begin
            pick = $urandom_range(99);
            if (pick < 65) begin
                set_random_pixels($urandom_range(1, 6));
                flush_until_done();
            end else if (pick < 75) begin
                set_random_pixels($urandom_range(1, 4));
                send_request(make_request(REQ_CLEAR, 8'($urandom_range(255)),
                                          8'($urandom_range(255))), n);
                flush_until_done();
            end else if (pick < 85) begin
                set_random_pixels($urandom_range(1, 4));
                send_request(make_request(REQ_FLUSH, 8'($urandom_range(255)),
                                          8'($urandom_range(255))), n);
            end else begin
                repeat ($urandom_range(1, 3)) begin
                    send_request(make_request(2'($urandom_range(3)), 8'($urandom_range(255)),
                                              8'($urandom_range(255))), n);
                end
            end
        end
        // The sender holds off until every outstanding panel byte has been taken.
        wait_results_drained();
    endtask

    always @(posedge i_clk) begin
        pop <= i_rst_n && ($urandom_range(99) >= recv_idle);
    end

    // Sampled mid-cycle, so the values are those seen at the next rising edge.
    always @(negedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && pop && !empty) begin
            if (panel_bytes_due.size() == 0) begin
                $error("unexpected panel byte: out_byte 0x%02h", o_res.out_byte);
                mismatches++;
            end else begin
                want = panel_bytes_due.pop_front();
                if (o_res.out_byte !== want.out_byte) begin
                    $error("out_byte: expected 0x%02h, got 0x%02h",
                           want.out_byte, o_res.out_byte);
                    mismatches++;
                end
                if (o_res.is_data !== want.is_data) begin
                    $error("is_data: expected %0b, got %0b", want.is_data, o_res.is_data);
                    mismatches++;
                end
                if (o_res.last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, o_res.last);
                    mismatches++;
                end
                if (o_res.scan_done !== want.scan_done) begin
                    $error("scan_done: expected %0b, got %0b",
                           want.scan_done, o_res.scan_done);
                    mismatches++;
                end
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("page_lcd_dirty_flush test failed");
        $finish;
    end

    initial begin
        foreach (drawn_bytes[i]) begin
            drawn_bytes[i] = 8'd0;
            shown_bytes[i] = 8'd0;
        end
        scan_idx = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle = 24;
        recv_idle = 62;
        test_directed_cases();
        test_random_traffic(24, 62, 60);
        test_random_traffic(62, 24, 60);
        test_random_traffic(0, 0, 60);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && panel_bytes_due.size() == 0) begin
            $display("page_lcd_dirty_flush test passed");
        end else begin
            $display("page_lcd_dirty_flush test failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
hdl/plcd_pkg.sv
hdl/plcd_front.sv
hdl/plcd_back.sv
hdl/plcd_out_queue.sv
hdl/page_lcd_dirty_flush.sv
hdl/plcd_checker.sv
tb/sv/tb_top.sv
